@@ design/sst_pkg.sv @@
// shared types, constants and op codes of the scoped symbol table
`default_nettype none
package sst_pkg;
   localparam int MAX_ENTRIES = 64;
   localparam int NAME_CHARS  = 8;
   localparam int MAX_NEST    = 16;
   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int NIDX_W  = $clog2(MAX_NEST);
   localparam int NCNT_W  = $clog2(MAX_NEST + 1);
   localparam int INFO_W  = 27;
   localparam int NEST_W  = 2 * CNT_W + 16;

   localparam logic [3:0] OP_INIT   = 4'd0;
   localparam logic [3:0] OP_CLEAR  = 4'd1;
   localparam logic [3:0] OP_LOOKUP = 4'd2;
   localparam logic [3:0] OP_AUTO   = 4'd3;
   localparam logic [3:0] OP_PARAM  = 4'd4;
   localparam logic [3:0] OP_STATIC = 4'd5;
   localparam logic [3:0] OP_REG    = 4'd6;
   localparam logic [3:0] OP_GLOBAL = 4'd7;
   localparam logic [3:0] OP_ENTER  = 4'd8;
   localparam logic [3:0] OP_EXIT   = 4'd9;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NEST_OVER = 3'd4;
   localparam logic [2:0] ST_NEST_UNDER = 3'd5;

   localparam logic [1:0] CLS_AUTO   = 2'd0;
   localparam logic [1:0] CLS_STATIC = 2'd1;
   localparam logic [1:0] CLS_REG    = 2'd2;
   localparam logic [1:0] CLS_EXTERN = 2'd3;

   localparam logic CSR_AUTO_START  = 1'b0;
   localparam logic CSR_PARAM_START = 1'b1;

   typedef struct packed {
      logic [3:0]  op;
      logic [63:0] sym_name;
      logic [7:0]  sym_type;
      logic [14:0] size;
      logic [14:0] label;
      logic [3:0]  reg_number;
      logic        global_static;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [1:0]         found_class;
      logic [7:0]         found_type;
      logic signed [15:0] found_offset;
      logic               found_static;
      logic signed [15:0] frame_low;
      logic signed [15:0] param_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, normalize name
      logic scan_start; // set scan pointer
      logic scan_step;  // compare one entry, step pointer
      logic exec;       // apply the op
      logic nest_rd;    // start nest read
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic hit;
   } stat_type;

   function automatic logic [63:0] norm_name(input logic [63:0] raw);
      logic [63:0] kept;
      logic        run;
      kept = '0;
      run  = 1'b1;
      for (int k = 0; k < NAME_CHARS; k++) begin
         if (raw[8*k +: 8] == 8'd0) run = 1'b0;
         if (run) kept[8*k +: 8] = raw[8*k +: 8];
      end
      return kept;
   endfunction
endpackage
`default_nettype wire

@@ design/scoped_symbol_table.sv @@
// top level of the scoped symbol table
// usage:
//   req channel: valid/ready transfer of one command (op, name, type, size,
//   label, register, static mark); rsp channel: one result per command
//   (status, found entry fields, frame low-water, running param offset)
//   csr port: write enable, index 0 auto_start, 1 param_start, no read-back
// sequence, from the request transfer to the result: load, then prepare;
//   init, clear, enter and unused ops then execute and offer the result;
//   exit first reads the nest store; lookup and declare walk the entry store
//   newest first, one entry a cycle, until a hit or the end of the search,
//   then read, execute and offer the result
// throughput: one command at a time; the next transfer is taken the cycle
//   after the result transfer, when the controller is back in idle
// reset: table and nest empty, offsets from the reset register values
//   (auto 0, param 4); stored entries are undefined until written
// stall: the result holds in its register while rsp_ready is low and
//   req_ready stays low until it is taken
`default_nettype none
module scoped_symbol_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sst_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sst_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_write_data
);
   import sst_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   logic [3:0] op_w;

   // sequencing of load, scan, store read, execute and result transfer
   sst_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .op_ff(op_w), .stat(stat), .cmd(cmd)
   );

   // stores, offsets and the result register
   sst_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_payload(req_payload), .cmd(cmd), .stat(stat),
      .op_out(op_w), .rsp_payload(rsp_payload)
   );
endmodule
`default_nettype wire

@@ design/sst_ctrl.sv @@
// controller state machine of the scoped symbol table
`default_nettype none
module sst_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic [3:0]       op_ff,
   input  wire sst_pkg::stat_type stat,
   output sst_pkg::cmd_type      cmd
);
   import sst_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_EXEC = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       is_search;

   assign is_search = (op_ff inside {[OP_LOOKUP:OP_GLOBAL]});
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (is_search) begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else if (op_ff == OP_EXIT) begin
               cmd.nest_rd = 1'b1;
               state_in = S_READ;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_SCAN: begin
            if (stat.scan_done || stat.hit) begin
               state_in = S_READ;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ design/sst_datapath.sv @@
// entry store, nest store, offsets and result register
`default_nettype none
module sst_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_write_data,
   input  wire sst_pkg::req_type  req_payload,
   input  wire sst_pkg::cmd_type  cmd,
   output sst_pkg::stat_type      stat,
   output logic [3:0]             op_out,
   output sst_pkg::rsp_type       rsp_payload
);
   import sst_pkg::*;

   logic [63:0]       name_mem [MAX_ENTRIES];
   logic [INFO_W-1:0] info_mem [MAX_ENTRIES];
   logic [NEST_W-1:0] nest_mem [MAX_NEST];

   req_type           req_ff;
   logic [63:0]       name_ff;
   logic [15:0]       auto_start_ff, param_start_ff;
   logic [CNT_W-1:0]  count_ff, mark_ff, ptr_ff;
   logic [15:0]       auto_ff, low_ff, param_ff;
   logic [NCNT_W-1:0] depth_ff;
   logic              hit_ff;
   logic [63:0]       rd_name_ff;
   logic [INFO_W-1:0] rd_info_ff;
   logic [NEST_W-1:0] nest_rd_ff;
   logic              rd_valid_ff;
   rsp_type           rsp_ff;

   // next values applied at exec
   logic [CNT_W-1:0]  count_in, mark_in;
   logic [NCNT_W-1:0] depth_in;
   logic [15:0]       auto_in, low_in, param_in;
   rsp_type           rsp_in;
   logic [CNT_W-1:0]  pop_count, pop_mark, pop_new_count;
   logic [15:0]       param_nx;

   logic [CNT_W-1:0]  floor_w;
   logic              is_decl;
   assign is_decl = (req_ff.op inside {[OP_AUTO:OP_GLOBAL]});
   assign floor_w = (!is_decl) ? '0 : ((mark_ff > count_ff) ? count_ff : mark_ff);

   // scan: read entry at ptr-1, compare next cycle
   logic rd_match;
   assign rd_match  = rd_valid_ff && (rd_name_ff == name_ff);
   assign stat.hit  = rd_match;
   assign stat.scan_done = (ptr_ff <= floor_w) && !rd_valid_ff;
   assign op_out    = req_ff.op;

   always_ff @(posedge clock) begin
      if (cmd.scan_step && ptr_ff > floor_w) begin
         rd_name_ff <= name_mem[ptr_ff[IDX_W-1:0] - 1'b1];
         rd_info_ff <= info_mem[ptr_ff[IDX_W-1:0] - 1'b1];
      end
      if (cmd.nest_rd && depth_ff != '0)
         nest_rd_ff <= nest_mem[NIDX_W'(depth_ff - 1'b1)];
   end

   // new entry built at exec
   logic [1:0]  n_cls;
   logic [15:0] n_off, auto_nx;
   logic        n_stat;
   always_comb begin
      auto_nx = auto_ff - {1'b0, req_ff.size};
      n_cls = CLS_AUTO; n_off = '0; n_stat = 1'b0;
      case (req_ff.op)
         OP_AUTO:   n_off = auto_nx;
         OP_PARAM:  n_off = param_ff;
         OP_STATIC: begin n_cls = CLS_STATIC; n_off = {1'b0, req_ff.label}; end
         OP_REG:    begin n_cls = CLS_REG; n_off = {12'd0, req_ff.reg_number}; end
         OP_GLOBAL: begin n_cls = CLS_EXTERN; n_stat = req_ff.global_static; end
         default:   n_cls = CLS_AUTO;
      endcase
   end

   logic do_write;
   assign do_write = cmd.exec && is_decl && !hit_ff && (count_ff < CNT_W'(MAX_ENTRIES));

   always_ff @(posedge clock) begin
      if (do_write) begin
         name_mem[count_ff[IDX_W-1:0]] <= name_ff;
         info_mem[count_ff[IDX_W-1:0]] <= {n_cls, req_ff.sym_type, n_off, n_stat};
      end
      if (cmd.exec && req_ff.op == OP_ENTER && depth_ff < NCNT_W'(MAX_NEST))
         nest_mem[depth_ff[NIDX_W-1:0]] <= {count_ff, mark_ff, auto_ff};
   end

   // state update and result of the op
   always_comb begin
      count_in = count_ff; mark_in = mark_ff; depth_in = depth_ff;
      auto_in = auto_ff; low_in = low_ff; param_in = param_ff;
      pop_count = nest_rd_ff[NEST_W-1 -: CNT_W];
      pop_mark  = nest_rd_ff[16 +: CNT_W];
      pop_new_count = (pop_count < count_ff) ? pop_count : count_ff;
      param_nx = param_ff + {1'b0, req_ff.size};
      rsp_in = '0;
      rsp_in.status = ST_OK;
      case (req_ff.op)
         OP_INIT: begin
            count_in = '0; mark_in = '0; depth_in = '0;
            auto_in = auto_start_ff; low_in = auto_start_ff;
            param_in = param_start_ff;
         end
         OP_CLEAR: begin
            count_in = '0; mark_in = '0; depth_in = '0;
         end
         OP_LOOKUP: begin
            if (hit_ff) begin
               rsp_in.found_class  = rd_info_ff[26:25];
               rsp_in.found_type   = rd_info_ff[24:17];
               rsp_in.found_offset = rd_info_ff[16:1];
               rsp_in.found_static = rd_info_ff[0];
            end else rsp_in.status = ST_NOT_FOUND;
         end
         OP_ENTER: begin
            if (depth_ff >= NCNT_W'(MAX_NEST)) rsp_in.status = ST_NEST_OVER;
            else begin
               depth_in = depth_ff + 1'b1;
               mark_in  = count_ff;
            end
         end
         OP_EXIT: begin
            if (depth_ff == '0) rsp_in.status = ST_NEST_UNDER;
            else begin
               depth_in = depth_ff - 1'b1;
               count_in = pop_new_count;
               mark_in  = (pop_mark > pop_new_count) ? pop_new_count : pop_mark;
               auto_in  = nest_rd_ff[15:0];
            end
         end
         default: begin
            if (is_decl) begin
               if (hit_ff) rsp_in.status = ST_DUPLICATE;
               else if (count_ff >= CNT_W'(MAX_ENTRIES)) rsp_in.status = ST_FULL;
               else begin
                  count_in = count_ff + 1'b1;
                  rsp_in.found_class  = n_cls;
                  rsp_in.found_type   = req_ff.sym_type;
                  rsp_in.found_offset = n_off;
                  rsp_in.found_static = n_stat;
                  if (req_ff.op == OP_AUTO) begin
                     auto_in = auto_nx;
                     if ($signed(auto_nx) < $signed(low_ff)) low_in = auto_nx;
                  end
                  if (req_ff.op == OP_PARAM) param_in = param_nx;
               end
            end
         end
      endcase
      rsp_in.frame_low   = low_in;
      rsp_in.param_total = param_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_payload;
         name_ff <= norm_name(req_payload.sym_name);
      end
      if (cmd.scan_start) ptr_ff <= count_ff;
      else if (cmd.scan_step && ptr_ff > floor_w) ptr_ff <= ptr_ff - 1'b1;
      if (cmd.scan_start) hit_ff <= 1'b0;
      else if (rd_match) hit_ff <= 1'b1;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_start_ff  <= 16'd0;
         param_start_ff <= 16'd4;
         count_ff <= '0; mark_ff <= '0; depth_ff <= '0;
         auto_ff <= 16'd0; low_ff <= 16'd0; param_ff <= 16'd4;
         rd_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_AUTO_START) auto_start_ff <= csr_write_data;
            else param_start_ff <= csr_write_data;
         end
         rd_valid_ff <= cmd.scan_step && (ptr_ff > floor_w);
         if (cmd.exec) begin
            count_ff <= count_in;
            mark_ff  <= mark_in;
            depth_ff <= depth_in;
            auto_ff  <= auto_in;
            low_ff   <= low_in;
            param_ff <= param_in;
         end
      end
   end

   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire
